/* hdl/csalu_pkg.sv */
package csalu_pkg;

	localparam int DATA_WIDTH = 32;

	typedef enum logic [1:0] {
		ACT_ADD,
		ACT_SUB,
		ACT_MUL,
		ACT_DIV
	} action_t;

	// one pipeline slot; rem/quo/dvs hold the divide state, and rem/dvs also carry the multiply magnitudes
	typedef struct packed {
		action_t                 act;
		logic                    neg;
		logic                    err;
		logic [DATA_WIDTH-1:0]   val;
		logic [DATA_WIDTH-1:0]   rem;
		logic [DATA_WIDTH-1:0]   quo;
		logic [DATA_WIDTH-1:0]   dvs;
	} slot_t;

endpackage

/* hdl/csalu_div.sv */
module csalu_div
	import csalu_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_i,
	input  slot_t slot_i,
	output logic  vld_o,
	output slot_t slot_o
);

	slot_t slot_sn [DATA_WIDTH];
	logic  vld_sn  [DATA_WIDTH];
	slot_t nxt     [DATA_WIDTH];

	for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
		slot_t                 cur;
		logic                  cur_vld;
		logic [DATA_WIDTH:0]   trial;
		logic                  ge;

		if (k == 0) begin : g_first
			assign cur     = slot_i;
			assign cur_vld = vld_i;
		end else begin : g_next
			assign cur     = slot_sn[k-1];
			assign cur_vld = vld_sn[k-1];
		end

		// restoring step: one quotient bit per stage
		always_comb begin
			trial = {cur.rem, cur.quo[DATA_WIDTH-1]} - {1'b0, cur.dvs};
			ge    = ~trial[DATA_WIDTH];
			nxt[k] = cur;
			nxt[k].rem = ge ? trial[DATA_WIDTH-1:0]
				: {cur.rem[DATA_WIDTH-2:0], cur.quo[DATA_WIDTH-1]};
			nxt[k].quo = {cur.quo[DATA_WIDTH-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k] <= 1'b0;
			end else if (en) begin
				vld_sn[k] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				slot_sn[k] <= nxt[k];
			end
		end
	end

	assign vld_o  = vld_sn[DATA_WIDTH-1];
	assign slot_o = slot_sn[DATA_WIDTH-1];

endmodule

/* hdl/checked_signed_integer_alu.sv */
// channel  | valid     | ready     | payload
// input    | in_valid  | in_ready  | action, operand_a, operand_b
// output   | out_valid | out_ready | result_value, error_flag
//
// one transaction enters per cycle while the output is not stalled;
// the divider resolves one quotient bit per stage
// all operations travel the same pipeline so results leave in order
// arst_n clears only the valid bits
// a stall at the output freezes every stage; in_ready follows that stall
module checked_signed_integer_alu
	import csalu_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   action,
	input  logic signed [DATA_WIDTH-1:0] operand_a,
	input  logic signed [DATA_WIDTH-1:0] operand_b,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] result_value,
	output logic                         error_flag
);

	localparam logic [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic en;
	assign en       = ~out_valid | out_ready;
	assign in_ready = en;

	// stage 1: magnitudes, add and subtract, divide-by-zero check
	logic [DATA_WIDTH-1:0] ma, mb, sum, dif;
	slot_t                 s1_d;
	action_t               act_in;

	always_comb begin
		act_in = action_t'(action);
		ma  = operand_a[DATA_WIDTH-1] ? -operand_a : operand_a;
		mb  = operand_b[DATA_WIDTH-1] ? -operand_b : operand_b;
		sum = operand_a + operand_b;
		dif = operand_a - operand_b;
		s1_d     = '0;
		s1_d.act = act_in;
		s1_d.neg = operand_a[DATA_WIDTH-1] ^ operand_b[DATA_WIDTH-1];
		s1_d.rem = ma;
		s1_d.dvs = mb;
		case (act_in)
			ACT_ADD: begin
				s1_d.val = sum;
				s1_d.err = (operand_a[DATA_WIDTH-1] == operand_b[DATA_WIDTH-1])
					&& (sum[DATA_WIDTH-1] != operand_a[DATA_WIDTH-1]);
			end
			ACT_SUB: begin
				s1_d.val = dif;
				s1_d.err = (operand_b == MinVal)
					|| ((operand_a[DATA_WIDTH-1] != operand_b[DATA_WIDTH-1])
					&& (dif[DATA_WIDTH-1] != operand_a[DATA_WIDTH-1]));
			end
			ACT_DIV: begin
				s1_d.err = (operand_b == '0);
			end
			default: begin
				s1_d.err = 1'b0;
			end
		endcase
	end

	slot_t slot_s1, slot_s2, slot_s3;
	logic  vld_s1, vld_s2, vld_s3;
	logic [2*DATA_WIDTH-1:0] prod_s2;

	// stage 3 input: multiply check, divider setup
	slot_t s3_d;
	logic [DATA_WIDTH-1:0] limit;
	always_comb begin
		limit = slot_s2.neg ? MinVal : ~MinVal;
		s3_d  = slot_s2;
		s3_d.quo = slot_s2.rem;
		s3_d.rem = '0;
		if (slot_s2.act == ACT_MUL) begin
			s3_d.err = (prod_s2 > {{DATA_WIDTH{1'b0}}, limit});
			s3_d.val = slot_s2.neg ? -prod_s2[DATA_WIDTH-1:0] : prod_s2[DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slot_s1 <= s1_d;
			slot_s2 <= slot_s1;
			prod_s2 <= slot_s1.rem * slot_s1.dvs;
			slot_s3 <= s3_d;
		end
	end

	logic  vld_dv;
	slot_t slot_dv;

	csalu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s3),
		.slot_i (slot_s3),
		.vld_o  (vld_dv),
		.slot_o (slot_dv)
	);

	// final: divide result and zeroing on error
	logic                  err_f;
	logic [DATA_WIDTH-1:0] val_f;
	always_comb begin
		err_f = slot_dv.err;
		val_f = slot_dv.val;
		if (slot_dv.act == ACT_DIV) begin
			err_f = slot_dv.err || (~slot_dv.neg && slot_dv.quo[DATA_WIDTH-1]);
			val_f = slot_dv.neg ? -slot_dv.quo : slot_dv.quo;
		end
	end

	logic                  vld_q;
	logic [DATA_WIDTH-1:0] res_q;
	logic                  err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= err_f ? '0 : val_f;
			err_q <= err_f;
		end
	end

	assign out_valid    = vld_q;
	assign result_value = res_q;
	assign error_flag   = err_q;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
	import csalu_pkg::*;

	typedef struct {
		action_t            act;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} alu_op_t;

	typedef struct {
		logic signed [31:0] value;
		logic               err;
	} alu_res_t;

	localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;
	localparam logic signed [31:0] MAX_VAL = 32'sh7fff_ffff;
	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = '0;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] result_value;
	logic error_flag;

	alu_op_t pending_ops[$];
	alu_res_t expected_results[$];
	int errors = 0;
	int cycle_count = 0;
	bit stim_done = 0;
	bit sender_hold = 0;
	bit sink_hold = 0;

	checked_signed_integer_alu u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// exact arithmetic in 64 bits, then range check
	function automatic alu_res_t compute_checked(alu_op_t op);
		alu_res_t r;
		logic signed [63:0] wide;
		r.value = '0;
		r.err = 1'b0;
		wide = '0;
		case (op.act)
			ACT_ADD: wide = 64'(op.a) + 64'(op.b);
			ACT_SUB: wide = 64'(op.a) - 64'(op.b);
			ACT_MUL: wide = 64'(op.a) * 64'(op.b);
			ACT_DIV: begin
				if (op.b == 0)
					r.err = 1'b1;
				else
					wide = 64'(op.a) / 64'(op.b);
			end
		endcase
		if (op.act == ACT_SUB && op.b == MIN_VAL)
			r.err = 1'b1;
		if (wide > 64'(MAX_VAL) || wide < 64'(MIN_VAL))
			r.err = 1'b1;
		if (!r.err)
			r.value = wide[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return MIN_VAL;
			1: return MAX_VAL;
			2: return 32'(int'($urandom_range(0, 6)) - 3);
			3: return 32'(int'($urandom_range(0, 131070)) - 65535);
			4: return MIN_VAL + 32'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	task automatic add_op(action_t act, logic signed [31:0] a, logic signed [31:0] b);
		alu_op_t op;
		op.act = act;
		op.a = a;
		op.b = b;
		pending_ops.push_back(op);
	endtask

	initial begin
		logic signed [31:0] corners[6];
		alu_op_t op;
		corners = '{MIN_VAL, MAX_VAL, 32'sd0, -32'sd1, 32'sd1, 32'sd2};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int k = 0; k < 4; k++)
			for (int j = 0; j < 6; j += 2)
				add_op(action_t'(k), corners[j], corners[(j + k + 1) % 6]);
		add_op(ACT_SUB, 32'sd5, MIN_VAL);
		add_op(ACT_DIV, MIN_VAL, -32'sd1);
		add_op(ACT_MUL, 32'sd0, MIN_VAL);
		add_op(ACT_DIV, -32'sd7, 32'sd2);
		add_op(ACT_ADD, MAX_VAL, MAX_VAL);
		add_op(ACT_MUL, 32'sd65536, 32'sd32768);
		add_op(ACT_MUL, -32'sd65536, 32'sd32768);
		for (int i = 0; i < 700; i++) begin
			op.act = action_t'($urandom_range(0, 3));
			op.a = pick_operand();
			op.b = pick_operand();
			// sender pause until drained once in the middle
			if (i == 300) begin
				wait (pending_ops.size() == 0);
				sender_hold = 1;
				wait (expected_results.size() == 0);
				sender_hold = 0;
			end
			pending_ops.push_back(op);
		end
		wait (pending_ops.size() == 0 && !in_valid);
		stim_done = 1;
	end

	// long receiver stall to fill the pipeline
	initial begin
		wait (arst_n);
		repeat (500) @(posedge clk);
		sink_hold = 1;
		repeat (200) @(posedge clk);
		sink_hold = 0;
	end

	// driver
	always @(posedge clk) begin
		alu_op_t op;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (pending_ops.size() > 0 && !sender_hold
						&& !(cycle_count % 1000 > 600 ? 0 : $urandom_range(0, 99) < 7)) begin
					op = pending_ops.pop_front();
					expected_results.push_back(compute_checked(op));
					in_valid <= 1'b1;
					action <= op.act;
					operand_a <= op.a;
					operand_b <= op.b;
				end else
					in_valid <= 1'b0;
			end
			out_ready <= !sink_hold
				&& (cycle_count % 1000 > 600 || $urandom_range(0, 99) >= 7);
		end
	end

	// monitor
	always @(posedge clk) begin
		alu_res_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected transaction: result_value %0d error_flag %0b",
					result_value, error_flag);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result_value !== exp_r.value) begin
					$error("result_value expected %0d actual %0d", exp_r.value, result_value);
					errors++;
				end
				if (error_flag !== exp_r.err) begin
					$error("error_flag expected %0b actual %0b", exp_r.err, error_flag);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	initial begin
		int idle;
		idle = 0;
		wait (arst_n);
		while (!(stim_done && expected_results.size() == 0)) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
			if (idle >= STALL_LIMIT) begin
				$display("checked_signed_integer_alu test failed");
				$finish;
			end
		end
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("checked_signed_integer_alu test passed");
		else
			$display("checked_signed_integer_alu test failed");
		$finish;
	end

endmodule
